### design/tsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  // Series length and output format
  localparam int unsigned SERIES_TERMS  = 10;
  localparam int unsigned OUT_FRAC_BITS = 30;

  localparam int unsigned AngleW = 9;
  localparam int unsigned OutW   = 32;

  // Internal values are magnitudes in Q.32, 8 integer bits
  localparam int unsigned Frac = 32;
  localparam int unsigned QW   = 40;
  localparam logic [QW-1:0] QOne = QW'(64'd1 << Frac);

  localparam int unsigned FullTurn = 360;
  localparam int unsigned HalfTurn = 180;

  // Degrees to radians: x = round(a * PiQ48 / (180 * 2^16)), split as
  // a * RadQuot + floor((a * RadRem + DegDen / 2) / DegDen)
  localparam logic [63:0] PiQ48  = 64'h0003_243F_6A88_85A3;
  localparam int unsigned RadShift = 16;
  localparam logic [63:0] DegDen = 64'(HalfTurn) << RadShift;

  localparam int unsigned QuotW = 27;
  localparam int unsigned RemW  = 24;
  localparam logic [QuotW-1:0] RadQuot    = QuotW'(PiQ48 / DegDen);
  localparam logic [RemW-1:0]  RadRem     = RemW'(PiQ48 % DegDen);
  localparam logic [RemW-1:0]  DegDenHalf = RemW'(DegDen / 2);

  // floor(n / 180) for any 16-bit n as (n * Div180Mult) >> Div180Shift
  localparam int unsigned DivNumW     = 16;
  localparam int unsigned Div180Shift = 23;
  localparam logic [DivNumW-1:0] Div180Mult =
    DivNumW'(((64'd1 << Div180Shift) + HalfTurn - 1) / HalfTurn);

endpackage

`default_nettype wire

### design/taylor_sine_cosine_of_degrees.sv
`timescale 1ns / 1ps
`default_nettype none

// Sine and cosine of a whole angle in degrees (0..511, taken modulo 360), as
// signed Q1.OUT_FRAC_BITS, from a Taylor series of SERIES_TERMS terms. The
// block takes one angle every clock cycle while stall_o is low and returns
// the pair through a pipeline whose depth is set by the term recurrence:
// each term waits on a two-stage split 40x40 multiply of the previous term,
// and the next series factor is formed alongside it. A stall freezes the
// whole pipeline only once the stage behind the held output is occupied.
module taylor_sine_cosine_of_degrees (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  output logic                                  stall_o,
  input  wire logic [tsc_pkg::AngleW-1:0]       angle_deg_i,
  output logic                                  valid_o,
  input  wire logic                             stall_i,
  output logic signed [tsc_pkg::OutW-1:0]       sine_value_o,
  output logic signed [tsc_pkg::OutW-1:0]       cosine_value_o
);

  localparam int unsigned NTerms   = tsc_pkg::SERIES_TERMS;
  localparam int unsigned QW       = tsc_pkg::QW;
  localparam int unsigned OutW     = tsc_pkg::OutW;
  localparam int unsigned AngleW   = tsc_pkg::AngleW;
  localparam int unsigned Depth    = 2 * NTerms + 10;
  localparam int unsigned AqW      = tsc_pkg::QuotW + AngleW;
  localparam int unsigned ArW      = tsc_pkg::RemW + AngleW;
  localparam int unsigned OutShift = tsc_pkg::Frac - tsc_pkg::OUT_FRAC_BITS;
  localparam int unsigned RndHalf  = 1 << (OutShift - 1);
  localparam logic [QW-1:0] PosLim = QW'((64'd1 << (OutW - 1)) - 1);
  localparam logic [QW-1:0] NegLim = QW'(64'd1 << (OutW - 1));
  localparam logic [QW-1:0] XLimit = QW'(7) << tsc_pkg::Frac;
  localparam bit LastNeg = ((NTerms - 1) % 2) == 1;

  localparam longint unsigned DSin1 = 6;
  localparam longint unsigned DCos1 = 2;
  localparam logic [QW-1:0] RSin1 = QW'(((64'd1 << tsc_pkg::Frac) + DSin1 / 2) / DSin1);
  localparam logic [QW-1:0] RCos1 = QW'(((64'd1 << tsc_pkg::Frac) + DCos1 / 2) / DCos1);

  function automatic logic [QW-1:0] round_mag(input logic [QW-1:0] v);
    logic [QW-1:0] r;
    r = v[QW-1] ? (~v + QW'(RndHalf + 1)) : (v + QW'(RndHalf));
    return r >> OutShift;
  endfunction

  function automatic logic [OutW-1:0] sat_out(input logic neg, input logic [QW-1:0] m);
    logic [OutW-1:0] r;
    if (!neg) begin
      r = (m > PosLim) ? PosLim[OutW-1:0] : m[OutW-1:0];
    end else begin
      r = (m > NegLim) ? NegLim[OutW-1:0] : (~m[OutW-1:0] + OutW'(1));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- control
  logic             adv;
  logic             out_en;
  logic [Depth-1:1] vld_q;
  logic             out_vld_q;

  assign out_en  = !out_vld_q || !stall_i;
  assign adv     = !(out_vld_q && stall_i && vld_q[Depth-1]);
  assign stall_o = !adv;
  assign valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[Depth-2:1], valid_i};
      end
      if (out_en) begin
        out_vld_q <= vld_q[Depth-1];
      end
    end
  end

  // -------------------------------------------------------------- front end
  logic [AngleW-1:0]         ang_red;
  logic [AngleW-1:0]         ang1_q;
  logic [AqW-1:0]            aq2_q, aq3_q, aq4_q;
  logic [ArW-1:0]            ar2_q;
  logic [ArW:0]              ar_sum;
  logic [tsc_pkg::DivNumW-1:0] n3_q;
  logic [2*tsc_pkg::DivNumW-1:0] div_prod;
  logic [AngleW-1:0]         qt4_q;
  logic [QW-1:0]             x5_q, x6_q, x7_q, x8_q, x9_q;
  logic [QW-1:0]             x2_7, x2_8_q;

  logic [QW-1:0] s_mag   [1:NTerms-1];
  logic [QW-1:0] c_mag   [1:NTerms-1];
  logic [QW-1:0] s_sum_q [1:NTerms-1];
  logic [QW-1:0] c_sum_q [1:NTerms-1];
  logic [QW-1:0] f_s     [0:NTerms-2];
  logic [QW-1:0] f_c     [0:NTerms-2];
  logic [QW-1:0] x2b     [0:NTerms-3];

  always_comb begin
    ang_red  = (angle_deg_i >= AngleW'(tsc_pkg::FullTurn))
             ? (angle_deg_i - AngleW'(tsc_pkg::FullTurn)) : angle_deg_i;
    ar_sum   = (ArW+1)'(ar2_q) + (ArW+1)'(tsc_pkg::DegDenHalf);
    div_prod = (2*tsc_pkg::DivNumW)'(n3_q) * (2*tsc_pkg::DivNumW)'(tsc_pkg::Div180Mult);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang1_q <= ang_red;
      aq2_q  <= AqW'(ang1_q) * AqW'(tsc_pkg::RadQuot);
      ar2_q  <= ArW'(ang1_q) * ArW'(tsc_pkg::RadRem);
      n3_q   <= ar_sum[tsc_pkg::RadShift +: tsc_pkg::DivNumW];
      aq3_q  <= aq2_q;
      qt4_q  <= div_prod[tsc_pkg::Div180Shift +: AngleW];
      aq4_q  <= aq3_q;
      x5_q   <= QW'(aq4_q) + QW'(qt4_q);
      x6_q   <= x5_q;
      x7_q   <= x6_q;
      x8_q   <= x7_q;
      x9_q   <= x8_q;
      x2_8_q <= x2_7;
      x2b[0] <= x2_8_q;
    end
  end

  tsc_qmul u_sq (
    .clk_i, .en_i(adv), .a_i(x5_q), .b_i(x5_q), .p_o(x2_7)
  );

  tsc_qmul u_fct1_s (
    .clk_i, .en_i(adv), .a_i(x2_7), .b_i(RSin1), .p_o(f_s[0])
  );

  tsc_qmul u_fct1_c (
    .clk_i, .en_i(adv), .a_i(x2_7), .b_i(RCos1), .p_o(f_c[0])
  );

  // ------------------------------------------------------------ term chain
  // Terms travel as magnitudes; term j is negative for odd j.
  for (genvar J = 0; J < NTerms - 1; J++) begin : g_step
    localparam bit TermNeg = (J % 2) == 1;

    logic [QW-1:0] s_mag_in, c_mag_in, s_sum_in, c_sum_in;
    logic [QW-1:0] s_mid_d, c_mid_d, s_mid_q, c_mid_q;

    if (J == 0) begin : g_first
      assign s_mag_in = x9_q;
      assign c_mag_in = tsc_pkg::QOne;
      assign s_sum_in = '0;
      assign c_sum_in = '0;
    end else begin : g_next
      assign s_mag_in = s_mag[J];
      assign c_mag_in = c_mag[J];
      assign s_sum_in = s_sum_q[J];
      assign c_sum_in = c_sum_q[J];
    end

    tsc_qmul u_term_s (
      .clk_i, .en_i(adv), .a_i(s_mag_in), .b_i(f_s[J]), .p_o(s_mag[J+1])
    );

    tsc_qmul u_term_c (
      .clk_i, .en_i(adv), .a_i(c_mag_in), .b_i(f_c[J]), .p_o(c_mag[J+1])
    );

    assign s_mid_d = s_sum_in + (TermNeg ? ~s_mag_in : s_mag_in) + QW'(TermNeg);
    assign c_mid_d = c_sum_in + (TermNeg ? ~c_mag_in : c_mag_in) + QW'(TermNeg);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_mid_q        <= s_mid_d;
        c_mid_q        <= c_mid_d;
        s_sum_q[J+1]   <= s_mid_q;
        c_sum_q[J+1]   <= c_mid_q;
      end
    end

    // factor for the following step, formed while this term is multiplied
    if (J + 2 < NTerms) begin : g_fct
      localparam longint unsigned K    = J + 2;
      localparam longint unsigned DSin = (2 * K) * (2 * K + 1);
      localparam longint unsigned DCos = (2 * K - 1) * (2 * K);
      localparam logic [QW-1:0] RSin =
        QW'(((64'd1 << tsc_pkg::Frac) + DSin / 2) / DSin);
      localparam logic [QW-1:0] RCos =
        QW'(((64'd1 << tsc_pkg::Frac) + DCos / 2) / DCos);

      tsc_qmul u_fct_s (
        .clk_i, .en_i(adv), .a_i(x2b[J]), .b_i(RSin), .p_o(f_s[J+1])
      );

      tsc_qmul u_fct_c (
        .clk_i, .en_i(adv), .a_i(x2b[J]), .b_i(RCos), .p_o(f_c[J+1])
      );

      if (J + 3 < NTerms) begin : g_x2
        logic [QW-1:0] x2_mid_q;

        always_ff @(posedge clk_i) begin
          if (adv) begin
            x2_mid_q <= x2b[J];
            x2b[J+1] <= x2_mid_q;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------ output end
  logic [QW-1:0]   fin_s_d, fin_c_d, fin_s_q, fin_c_q;
  logic [QW-1:0]   rnd_s_q, rnd_c_q;
  logic            neg_s_q, neg_c_q;
  logic [OutW-1:0] sin_q, cos_q;

  assign fin_s_d = s_sum_q[NTerms-1]
                 + (LastNeg ? ~s_mag[NTerms-1] : s_mag[NTerms-1]) + QW'(LastNeg);
  assign fin_c_d = c_sum_q[NTerms-1]
                 + (LastNeg ? ~c_mag[NTerms-1] : c_mag[NTerms-1]) + QW'(LastNeg);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_s_q <= fin_s_d;
      fin_c_q <= fin_c_d;
      rnd_s_q <= round_mag(fin_s_q);
      rnd_c_q <= round_mag(fin_c_q);
      neg_s_q <= fin_s_q[QW-1];
      neg_c_q <= fin_c_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      sin_q <= sat_out(neg_s_q, rnd_s_q);
      cos_q <= sat_out(neg_c_q, rnd_c_q);
    end
  end

  assign sine_value_o   = $signed(sin_q);
  assign cosine_value_o = $signed(cos_q);

  // ------------------------------------------------------------ assertions
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a held result");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> vld_q[1])
    else $error("accepted transaction missing from first stage");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i && vld_q[Depth-1]) |=> vld_q[Depth-1])
    else $error("stage behind held output was lost");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (x5_q < XLimit))
    else $error("radian value out of range");

endmodule

`default_nettype wire

### design/tsc_qmul.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned Q.32 product, rounded to nearest (ties up), two register stages.
module tsc_qmul (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [tsc_pkg::QW-1:0] a_i,
  input  wire logic [tsc_pkg::QW-1:0] b_i,
  output logic      [tsc_pkg::QW-1:0] p_o
);

  localparam int unsigned HW = tsc_pkg::QW / 2;
  localparam int unsigned PW = 2 * tsc_pkg::QW;
  localparam logic [PW-1:0] RoundBit = PW'(1) << (tsc_pkg::Frac - 1);

  logic [2*HW-1:0] pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [PW-1:0]   prod_sum;
  logic [tsc_pkg::QW-1:0] p_q;

  // stage 1: four half-width partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_hh_q <= (2*HW)'(a_i[tsc_pkg::QW-1:HW]) * (2*HW)'(b_i[tsc_pkg::QW-1:HW]);
      pp_hl_q <= (2*HW)'(a_i[tsc_pkg::QW-1:HW]) * (2*HW)'(b_i[HW-1:0]);
      pp_lh_q <= (2*HW)'(a_i[HW-1:0]) * (2*HW)'(b_i[tsc_pkg::QW-1:HW]);
      pp_ll_q <= (2*HW)'(a_i[HW-1:0]) * (2*HW)'(b_i[HW-1:0]);
    end
  end

  // stage 2: recombine with the rounding half folded in, drop 32 fraction bits
  always_comb begin
    prod_sum = {pp_hh_q, {(2*HW){1'b0}}} + (PW'(pp_hl_q) << HW) + (PW'(pp_lh_q) << HW)
             + PW'(pp_ll_q) + RoundBit;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= prod_sum[tsc_pkg::Frac +: tsc_pkg::QW];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
